/* sv/scf_pkg.sv */
// Shared constants, types and helpers for the strip cluster finder.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

    // Geometry and field widths
    localparam int NUM_STRIPS   = 128;
    localparam int IDX_W        = $clog2(NUM_STRIPS);
    localparam int ENERGY_BITS  = 18;
    localparam int BIN_W        = ENERGY_BITS + 2;
    localparam int STRIP_W      = 7;
    localparam int HIT_THR_W    = 18;
    localparam int PEAK_W       = 17;
    localparam int MAX_RESULTS  = 64;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int SUM_W        = BIN_W - 1 + IDX_W;
    localparam int WSUM_W       = SUM_W + IDX_W;
    localparam int CL_ENERGY_W  = 26;
    localparam int POS_W        = 15;
    localparam int FRAC_W       = 8;
    localparam int WIDTH_W      = 8;
    localparam int REGION_W     = 2;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [CL_ENERGY_W-1:0] CL_ENERGY_MAX = '1;

    // Pitch region codes
    localparam logic [REGION_W-1:0] REG_GUARD  = 2'd0;
    localparam logic [REGION_W-1:0] REG_FINE   = 2'd1;
    localparam logic [REGION_W-1:0] REG_MEDIUM = 2'd2;
    localparam logic [REGION_W-1:0] REG_COARSE = 2'd3;

    // Input mode codes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_HIT    = 2'd1;
    localparam logic [1:0] MODE_EOE    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_HIT,
        OP_EOE
    } scf_op_t;

    typedef struct packed {
        scf_op_t                      op;
        logic [STRIP_W-1:0]           strip;
        logic signed [ENERGY_BITS-1:0] energy;
        logic signed [HIT_THR_W-1:0]  hit_thr;
        logic [PEAK_W-1:0]            peak_thr;
    } scf_item_t;

    typedef struct packed {
        logic                   cluster_valid;
        logic [CL_ENERGY_W-1:0] cluster_energy;
        logic [POS_W-1:0]       cluster_position;
        logic [WIDTH_W-1:0]     cluster_width;
        logic [REGION_W-1:0]    pitch_region;
        logic                   last;
    } scf_res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HIT_CHK,
        ST_SCAN,
        ST_SCAN_END,
        ST_SEED,
        ST_SEED_CHK,
        ST_EMIT_PEND,
        ST_GROW_LO,
        ST_LO_CHK,
        ST_GROW_HI,
        ST_HI_CHK,
        ST_ACC_RD,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } scf_state_t;

    // Pitch region from the integer strip part of the position
    function automatic logic [REGION_W-1:0] region_of(input logic [POS_W-FRAC_W-1:0] p);
        logic [REGION_W-1:0] r;
        if (p < 7'd4 || p >= 7'd123)  r = REG_GUARD;
        else if (p < 7'd28)           r = REG_COARSE;
        else if (p < 7'd48)           r = REG_MEDIUM;
        else if (p < 7'd79)           r = REG_FINE;
        else if (p < 7'd99)           r = REG_MEDIUM;
        else                          r = REG_COARSE;
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/strip_cluster_finder.sv */
// Top level of the strip cluster finder.
//
// Usage: input words arrive on s_tvalid/s_tready with the mode in s_tuser.
// Mode 0 loads the hit and peak thresholds of one strip, mode 1 adds a hit
// energy to its strip bin, mode 2 closes the event and starts the cluster
// search; mode 3 words are accepted and dropped. Results leave on m_ with
// the cluster-found flag in m_tuser and m_tlast on the final word of the
// event; an empty event yields one word with m_tuser low.
// Timing: a four-word queue decouples input from the engine. A load writes
// the tables directly; a hit registers its bin and threshold read, then
// writes the bin. Each search runs the maximum scan and seed test, then
// hands a held cluster to the output register; a found cluster then probes
// neighbors (read, check), reads, multiplies and adds each run strip, and
// waits for the position divider. The end of event adds a final failed
// search (unless the result limit is hit) and then drops all bin valid bits.
// Reset clears control state and every bin valid bit at once; threshold
// tables are undefined until loaded. A stalled receiver holds the output
// register and the engine waits at its next result.
`timescale 1ns / 1ps
`default_nettype none

module strip_cluster_finder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // strip[6:0], energy[24:7], hit_threshold[42:25],
                                       // peak_threshold[59:43]
    input  wire logic [1:0]  s_tuser,  // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // cluster_energy[25:0], cluster_position[40:26],
                                       // cluster_width[48:41], pitch_region[50:49]
    output logic             m_tuser,  // cluster_valid
    output logic             m_tlast   // last
);
    import scf_pkg::*;

    logic       item_valid, item_pop;
    scf_item_t  item;
    scf_res_t   res;

    scf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    scf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (res)
    );

    assign m_tdata = {5'd0, res.pitch_region, res.cluster_width,
                      res.cluster_position, res.cluster_energy};
    assign m_tuser = res.cluster_valid;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

/* sv/scf_front.sv */
// Input side: accepts words, decodes the mode and queues work for the engine.
`timescale 1ns / 1ps
`default_nettype none

module scf_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [63:0]       s_tdata,  // strip, energy, hit_threshold, peak_threshold
    input  wire logic [1:0]        s_tuser,  // mode
    output logic                   item_valid,
    output scf_pkg::scf_item_t     item,
    input  wire logic              item_pop
);
    import scf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    scf_item_t          fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               push, pop;
    scf_item_t          dec;

    // Decode the word; unknown mode is dropped here
    always_comb begin
        dec.strip    = s_tdata[6:0];
        dec.energy   = signed'(s_tdata[24:7]);
        dec.hit_thr  = signed'(s_tdata[42:25]);
        dec.peak_thr = s_tdata[59:43];
        case (s_tuser)
            MODE_LOAD: dec.op = OP_LOAD;
            MODE_HIT:  dec.op = OP_HIT;
            default:   dec.op = OP_EOE;
        endcase
    end

    assign s_tready   = (count_reg != (PTR_W+1)'(FIFO_DEPTH));
    assign push       = s_tvalid && s_tready && (s_tuser != MODE_UNUSED);
    assign item_valid = (count_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= dec;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/scf_div.sv */
// Restoring divider, one quotient bit per cycle, for the cluster position.
`timescale 1ns / 1ps
`default_nettype none

module scf_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [scf_pkg::WSUM_W-1:0]  wsum,
    input  wire logic [scf_pkg::SUM_W-1:0]   sum,
    output logic                             done,
    output logic [scf_pkg::POS_W-1:0]        quot
);
    import scf_pkg::*;

    localparam int CNT_B = $clog2(POS_W);
    localparam int HI_SH = POS_W - FRAC_W;

    logic                 busy_reg, done_reg;
    logic [CNT_B-1:0]     cnt_reg;
    logic [SUM_W-1:0]     rem_reg, div_reg;
    logic [POS_W-1:0]     sh_reg;
    logic [SUM_W:0]       rem2, diff;
    logic                 ge;

    // One step: shift in a dividend bit, subtract if it fits
    always_comb begin
        rem2 = {rem_reg, sh_reg[POS_W-1]};
        ge   = (rem2 >= {1'b0, div_reg});
        diff = rem2 - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= SUM_W'(wsum >> HI_SH);
            sh_reg  <= {wsum[HI_SH-1:0], FRAC_W'(0)};
            div_reg <= sum;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[SUM_W-1:0] : rem2[SUM_W-1:0];
            sh_reg  <= {sh_reg[POS_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_B'(POS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

`default_nettype wire

/* sv/scf_back.sv */
// Engine: threshold tables, strip bins, cluster search and result register.
`timescale 1ns / 1ps
`default_nettype none

module scf_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    input  wire scf_pkg::scf_item_t item,
    output logic                    item_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output scf_pkg::scf_res_t       m_res
);
    import scf_pkg::*;

    // Memories
    logic [BIN_W-1:0]       bin_mem  [NUM_STRIPS];
    logic [HIT_THR_W-1:0]   hit_mem  [NUM_STRIPS];
    logic [PEAK_W-1:0]      peak_mem [NUM_STRIPS];
    logic [NUM_STRIPS-1:0]  bin_vld_reg;
    logic [BIN_W-1:0]       bin_rd_reg;
    logic                   bin_rdv_reg;
    logic signed [HIT_THR_W-1:0] hit_rd_reg;
    logic [PEAK_W-1:0]      peak_rd_reg;

    logic [IDX_W-1:0]       bin_ra, thr_ra, bin_wa, clr_idx;
    logic                   bin_we, thr_we, clr_en, clr_all;
    logic [BIN_W-1:0]       bin_wd;
    logic signed [BIN_W-1:0] bin_q;

    // Control state
    scf_state_t             state_reg, state_next;
    scf_item_t              cur_reg, cur_next;
    logic [IDX_W-1:0]       idx_reg, idx_next, idxd_reg, idxd_next;
    logic                   cmpv_reg, cmpv_next;
    logic [IDX_W-1:0]       mx_reg, mx_next, lo_reg, lo_next, hi_reg, hi_next;
    logic signed [BIN_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [WSUM_W-1:0]      wsum_reg, wsum_next;
    logic [BIN_W-2+IDX_W:0] prod_reg, prod_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    scf_res_t               pend_reg, pend_next, res_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic                   m_vld_reg, m_vld_next;
    scf_res_t               m_dat_reg, m_dat_next;
    logic                   out_free, div_start, div_done;
    logic [POS_W-1:0]       div_q;
    logic signed [BIN_W:0]  hit_sum;
    logic [BIN_W-1:0]       hit_sat;

    localparam logic signed [BIN_W:0] BIN_MAX = (BIN_W+1)'((1 << (BIN_W - 1)) - 1);
    localparam logic signed [BIN_W:0] BIN_MIN = -(BIN_W+1)'(1 << (BIN_W - 1));
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(NUM_STRIPS - 1);

    // Bin memory with per-strip valid bits; an invalid strip reads zero
    always_ff @(posedge aclk) begin
        if (bin_we) bin_mem[bin_wa] <= bin_wd;
        bin_rd_reg <= bin_mem[bin_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
            bin_rdv_reg <= 1'b0;
        end else begin
            bin_rdv_reg <= bin_vld_reg[bin_ra];
            if (clr_all) begin
                bin_vld_reg <= '0;
            end else begin
                if (bin_we) bin_vld_reg[bin_wa] <= 1'b1;
                if (clr_en) bin_vld_reg[clr_idx] <= 1'b0;
            end
        end
    end

    assign bin_q = bin_rdv_reg ? signed'(bin_rd_reg) : '0;

    // Threshold tables
    always_ff @(posedge aclk) begin
        if (thr_we) begin
            hit_mem[thr_ra]  <= item.hit_thr;
            peak_mem[thr_ra] <= item.peak_thr;
        end
        hit_rd_reg  <= signed'(hit_mem[thr_ra]);
        peak_rd_reg <= peak_mem[thr_ra];
    end

    // Saturating bin update for a hit
    always_comb begin
        hit_sum = (BIN_W+1)'(bin_q) + (BIN_W+1)'(cur_reg.energy);
        if (hit_sum > BIN_MAX)      hit_sat = BIN_MAX[BIN_W-1:0];
        else if (hit_sum < BIN_MIN) hit_sat = BIN_MIN[BIN_W-1:0];
        else                        hit_sat = hit_sum[BIN_W-1:0];
    end

    assign out_free = !m_vld_reg || m_tready;

    scf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .wsum    (wsum_reg),
        .sum     (sum_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    // Finished cluster word
    always_comb begin
        res_next.cluster_valid    = 1'b1;
        res_next.cluster_energy   = (sum_reg > SUM_W'(CL_ENERGY_MAX)) ? CL_ENERGY_MAX
                                    : CL_ENERGY_W'(sum_reg);
        res_next.cluster_position = div_q;
        res_next.cluster_width    = WIDTH_W'({1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1);
        res_next.pitch_region     = region_of(div_q[POS_W-1:FRAC_W]);
        res_next.last             = 1'b0;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        idxd_next     = idxd_reg;
        cmpv_next     = cmpv_reg;
        mx_next       = mx_reg;
        max_next      = max_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        sum_next      = sum_reg;
        wsum_next     = wsum_reg;
        prod_next     = prod_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        m_vld_next    = m_vld_reg && !m_tready;
        m_dat_next    = m_dat_reg;
        item_pop      = 1'b0;
        bin_ra        = idx_reg;
        thr_ra        = item.strip[IDX_W-1:0];
        thr_we        = 1'b0;
        bin_we        = 1'b0;
        bin_wa        = cur_reg.strip[IDX_W-1:0];
        bin_wd        = hit_sat;
        clr_en        = 1'b0;
        clr_idx       = idx_reg;
        clr_all       = 1'b0;
        div_start     = 1'b0;

        // running maximum while scanning, lowest strip wins a tie
        if ((state_reg == ST_SCAN || state_reg == ST_SCAN_END) && cmpv_reg &&
            (idxd_reg == '0 || bin_q > max_reg)) begin
            mx_next  = idxd_reg;
            max_next = bin_q;
        end

        case (state_reg)
            ST_IDLE: begin
                bin_ra = item.strip[IDX_W-1:0];
                if (item_valid) begin
                    item_pop = 1'b1;
                    cur_next = item;
                    case (item.op)
                        OP_LOAD: begin
                            thr_we = (int'(item.strip) < NUM_STRIPS);
                        end
                        OP_HIT: begin
                            if (int'(item.strip) < NUM_STRIPS) state_next = ST_HIT_CHK;
                        end
                        default: begin
                            idx_next   = '0;
                            cmpv_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_HIT_CHK: begin
                bin_we     = (cur_reg.energy >= hit_rd_reg);
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                cmpv_next = 1'b1;
                idxd_next = idx_reg;
                if (idx_reg == LAST_IDX) state_next = ST_SCAN_END;
                else                     idx_next   = idx_reg + 1'b1;
            end
            ST_SCAN_END: begin
                cmpv_next  = 1'b0;
                state_next = ST_SEED;
            end
            ST_SEED: begin
                thr_ra     = mx_reg;
                state_next = ST_SEED_CHK;
            end
            ST_SEED_CHK: begin
                lo_next = mx_reg;
                hi_next = mx_reg;
                if ((BIN_W+1)'(max_reg) > signed'((BIN_W+1)'(peak_rd_reg))) begin
                    state_next = pend_vld_reg ? ST_EMIT_PEND : ST_GROW_LO;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_EMIT_PEND: begin
                if (out_free) begin
                    m_vld_next    = 1'b1;
                    m_dat_next    = pend_reg;
                    pend_vld_next = 1'b0;
                    state_next    = ST_GROW_LO;
                end
            end
            ST_GROW_LO: begin
                bin_ra = lo_reg - 1'b1;
                state_next = (lo_reg == '0) ? ST_GROW_HI : ST_LO_CHK;
            end
            ST_LO_CHK: begin
                if (bin_q > 0) begin
                    lo_next    = lo_reg - 1'b1;
                    state_next = ST_GROW_LO;
                end else begin
                    state_next = ST_GROW_HI;
                end
            end
            ST_GROW_HI: begin
                bin_ra = hi_reg + 1'b1;
                if (hi_reg == LAST_IDX) begin
                    idx_next   = lo_reg;
                    sum_next   = '0;
                    wsum_next  = '0;
                    state_next = ST_ACC_RD;
                end else begin
                    state_next = ST_HI_CHK;
                end
            end
            ST_HI_CHK: begin
                if (bin_q > 0) begin
                    hi_next    = hi_reg + 1'b1;
                    state_next = ST_GROW_HI;
                end else begin
                    idx_next   = lo_reg;
                    sum_next   = '0;
                    wsum_next  = '0;
                    state_next = ST_ACC_RD;
                end
            end
            ST_ACC_RD: begin
                clr_en     = 1'b1;
                state_next = ST_ACC_MUL;
            end
            ST_ACC_MUL: begin
                prod_next  = bin_q[BIN_W-2:0] * idx_reg;
                sum_next   = sum_reg + SUM_W'(bin_q[BIN_W-2:0]);
                state_next = ST_ACC_ADD;
            end
            ST_ACC_ADD: begin
                wsum_next = wsum_reg + WSUM_W'(prod_reg);
                if (idx_reg == hi_reg) begin
                    state_next = ST_DIV_GO;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ACC_RD;
                end
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    pend_next     = res_next;
                    pend_vld_next = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    idx_next      = '0;
                    cmpv_next     = 1'b0;
                    state_next    = (cnt_reg == CNT_W'(MAX_RESULTS - 1)) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_vld_next = 1'b1;
                    if (pend_vld_reg) begin
                        m_dat_next      = pend_reg;
                        m_dat_next.last = 1'b1;
                    end else begin
                        m_dat_next      = '0;
                        m_dat_next.last = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    cnt_next      = '0;
                    clr_all       = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cmpv_reg     <= 1'b0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmpv_reg     <= cmpv_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        idxd_reg  <= idxd_next;
        mx_reg    <= mx_next;
        max_reg   <= max_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        sum_reg   <= sum_next;
        wsum_reg  <= wsum_next;
        prod_reg  <= prod_next;
        pend_reg  <= pend_next;
        m_dat_reg <= m_dat_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_res    = m_dat_reg;

    // Checks
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (bin_vld_reg == '0))
        else $error("bins not cleared at end of event");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("cluster count beyond limit");
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");
    a_acc_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC_RD) |-> (lo_reg <= idx_reg && idx_reg <= hi_reg))
        else $error("accumulate index outside run");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the strip cluster finder: directed table plus random events.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import scf_pkg::*;

    // Strips that random hits land on; all of them get thresholds first
    localparam int HIT_SPAN = 32;

    // Expected result word
    typedef struct packed {
        logic        found;
        logic [25:0] esum;
        logic [14:0] pos;
        logic [7:0]  width;
        logic [1:0]  region;
        logic        lst;
    } cluster_t;

    // Directed stimulus row; chk asks for a typed-in result on an end of event
    typedef struct {
        logic [1:0]  mode;
        logic [6:0]  strip;
        logic [17:0] energy;
        logic [17:0] hthr;
        logic [16:0] pthr;
        bit          chk;
        cluster_t    want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    strip_cluster_finder uut (.*);

    always #5 aclk = ~aclk;

    // Predictor state
    logic signed [BIN_W-1:0]     bin_q [NUM_STRIPS];
    logic signed [HIT_THR_W-1:0] hthr_q [NUM_STRIPS];
    logic [PEAK_W-1:0]           pthr_q [NUM_STRIPS];
    cluster_t                    clusters_due [$];
    cluster_t                    typed_due [$];
    int errors = 0;
    int n_words = 0, n_events = 0, n_clusters = 0;
    bit calm = 0;          // no idling stretch
    bit hold_rx = 0;       // long receiver stall

    function automatic logic [1:0] pitch_of(input int p);
        if (p < 4 || p >= 123) return REG_GUARD;
        if (p < 28) return REG_COARSE;
        if (p < 48) return REG_MEDIUM;
        if (p < 79) return REG_FINE;
        if (p < 99) return REG_MEDIUM;
        return REG_COARSE;
    endfunction

    // Update state and queue the clusters one word causes
    task automatic predict_word(input logic [1:0] mode, input logic [6:0] strip,
                                input logic [17:0] energy, input logic [17:0] hthr,
                                input logic [16:0] pthr);
        longint b, lo, hi, mx, sum, wsum, pos;
        int n;
        cluster_t c;
        n = 0;
        if (mode == MODE_LOAD) begin
            hthr_q[strip] = hthr;
            pthr_q[strip] = pthr;
        end else if (mode == MODE_HIT) begin
            if ($signed(energy) >= hthr_q[strip]) begin
                b = longint'(bin_q[strip]) + longint'($signed(energy));
                if (b > (1 << (BIN_W - 1)) - 1) b = (1 << (BIN_W - 1)) - 1;
                if (b < -(1 << (BIN_W - 1))) b = -(1 << (BIN_W - 1));
                bin_q[strip] = BIN_W'(b);
            end
        end else if (mode == MODE_EOE) begin
            while (n < MAX_RESULTS) begin
                mx = 0;
                for (int i = 1; i < NUM_STRIPS; i++)
                    if (bin_q[i] > bin_q[mx]) mx = i;
                if (!(longint'(bin_q[mx]) > longint'(pthr_q[mx]))) break;
                lo = mx;
                while (lo > 0 && bin_q[lo-1] > 0) lo--;
                hi = mx;
                while (hi < NUM_STRIPS - 1 && bin_q[hi+1] > 0) hi++;
                sum = 0; wsum = 0;
                for (longint i = lo; i <= hi; i++) begin
                    sum += bin_q[i];
                    wsum += longint'(bin_q[i]) * i;
                    bin_q[i] = 0;
                end
                pos = (wsum << 8) / sum;
                c.found = 1'b1;
                c.esum = sum > 67108863 ? 26'h3FFFFFF : sum[25:0];
                c.pos = pos > 32767 ? 15'h7FFF : pos[14:0];
                c.width = 8'(hi - lo + 1);
                c.region = pitch_of(int'(pos >> 8));
                c.lst = 1'b0;
                clusters_due.push_back(c);
                n++;
            end
            if (n == 0) begin
                c = '{1'b0, '0, '0, '0, '0, 1'b1};
                clusters_due.push_back(c);
            end else begin
                clusters_due[$].lst = 1'b1;
            end
            for (int i = 0; i < NUM_STRIPS; i++) bin_q[i] = 0;
        end
    endtask

    // Send one word, wait for the handshake; idling gaps at random
    task automatic send_word(input logic [1:0] mode, input logic [6:0] strip,
                             input logic [17:0] energy, input logic [17:0] hthr,
                             input logic [16:0] pthr);
        while (!calm && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {4'b0, pthr, hthr, energy, strip};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(mode, strip, energy, hthr, pthr);
        n_words++;
        if (mode == MODE_EOE) n_events++;
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (clusters_due.size() != 0) @(posedge aclk);
    endtask

    // Receiver side: stall at random, or hold off while hold_rx is set
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_rx && (calm || $urandom_range(99) >= 9);
    end

    // Result checker
    always @(posedge aclk) begin
        cluster_t w, g;
        if (aresetn && m_tvalid && m_tready) begin
            g.found = m_tuser;
            g.esum = m_tdata[25:0];
            g.pos = m_tdata[40:26];
            g.width = m_tdata[48:41];
            g.region = m_tdata[50:49];
            g.lst = m_tlast;
            if (clusters_due.size() == 0) begin
                $display("%0t: result with none expected: %p", $time, g);
                errors++;
            end else begin
                w = clusters_due.pop_front();
                if (g.found && g.lst) n_clusters++;
                else if (g.found) n_clusters++;
                if (g !== w) begin
                    $display("%0t: mismatch expected %p actual %p", $time, w, g);
                    errors++;
                end
                if (typed_due.size() != 0 && g.lst) begin
                    w = typed_due.pop_front();
                    if (w.found !== g.found || w.esum !== g.esum || w.width !== g.width) begin
                        $display("%0t: directed mismatch expected %p actual %p",
                                 $time, w, g);
                        errors++;
                    end
                end
            end
        end
    end

    // Long receiver stall, counted here
    task automatic stall_receiver(input int cycles);
        hold_rx = 1;
        repeat (cycles) @(posedge aclk);
        hold_rx = 0;
    endtask

    row_t dir_rows [$];

    initial begin
        logic [4:0] base;
        logic [6:0] st;
        int k, len;
        bit stalled, drained;
        stalled = 0;
        drained = 0;
        for (int i = 0; i < NUM_STRIPS; i++) begin
            bin_q[i] = 0; hthr_q[i] = 0; pthr_q[i] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load the strips that random hits use, so no undefined threshold is read
        calm = 1;
        for (int i = 0; i < HIT_SPAN; i++)
            send_word(MODE_LOAD, 7'(i), 18'($urandom), 18'h20000, 17'd256);
        calm = 0;

        // Directed table
        dir_rows = '{
            // empty event
            '{MODE_EOE, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}},
            // edge strips with extreme thresholds; the top strip is the
            // largest bin but never above its peak threshold, so no cluster
            '{MODE_LOAD, 0, 0, 18'h20000, 17'd0, 0, '{0,0,0,0,0,0}},
            '{MODE_LOAD, 127, 0, 18'h1FFFF, 17'h1FFFF, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 0, 18'd1, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 127, 18'h1FFFF, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_EOE, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}},
            // saturation of a bin, single strip cluster at strip 60
            '{MODE_LOAD, 60, 0, 18'h20000, 17'd0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 60, 18'h1FFFF, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 60, 18'h1FFFF, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 60, 18'h1FFFF, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 60, 18'h1FFFF, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 60, 18'h1FFFF, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_EOE, 0, 0, 0, 0, 1, '{1, 26'h7FFFF, 0, 8'd1, REG_FINE, 1}},
            // negative energy, hit below threshold, unknown mode
            '{MODE_LOAD, 30, 0, 18'h3FF00, 17'd0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 30, 18'h20000, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 30, 18'h3FF00, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_UNUSED, 7'h7F, 18'h3FFFF, 18'h3FFFF, 17'h1FFFF, 0, '{0,0,0,0,0,0}},
            '{MODE_EOE, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}},
            // tie: two equal peaks joined in one run
            '{MODE_LOAD, 5, 0, 18'h20000, 17'd0, 0, '{0,0,0,0,0,0}},
            '{MODE_LOAD, 6, 0, 18'h20000, 17'd0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 5, 18'd512, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_HIT, 6, 18'd512, 0, 0, 0, '{0,0,0,0,0,0}},
            '{MODE_EOE, 0, 0, 0, 0, 1, '{1, 26'd1024, 0, 8'd2, REG_COARSE, 1}}
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].chk) typed_due.push_back(dir_rows[i].want);
            send_word(dir_rows[i].mode, dir_rows[i].strip, dir_rows[i].energy,
                      dir_rows[i].hthr, dir_rows[i].pthr);
        end

        // Random events: mostly clustered hits, some noise and reloads
        k = 0;
        while (k < 95) begin
            if ($urandom_range(7) == 0) begin
                st = 7'($urandom);
                send_word(MODE_LOAD, st, 18'($urandom),
                          $urandom_range(1) ? 18'h20000 : 18'($urandom),
                          $urandom_range(1) ? 17'($urandom_range(4000)) : 17'($urandom));
                k++;
            end
            for (int c = $urandom_range(4); c > 0; c--) begin
                base = 5'($urandom);
                len = $urandom_range(1, 5);
                for (int j = 0; j < len; j++) begin
                    send_word(MODE_HIT, {2'b00, base + 5'(j)},
                              $urandom_range(3) == 0 ? 18'($urandom)
                                                     : 18'($urandom_range(20000)),
                              18'($urandom), 17'($urandom));
                    k++;
                end
            end
            if ($urandom_range(5) == 0) begin
                send_word(MODE_UNUSED, 7'($urandom), 18'($urandom), 18'($urandom),
                          17'($urandom));
            end
            send_word(MODE_EOE, 7'($urandom), 18'($urandom), 18'($urandom), 17'($urandom));
            k++;
            if (!stalled && k > 30) begin
                // block the receiver while enough events are sent to fill the queue
                stalled = 1;
                fork
                    stall_receiver(3000);
                    repeat (10) send_word(MODE_EOE, 7'd0, 18'd0, 18'd0, 17'd0);
                join
            end
            if (!drained && k > 55) begin
                drained = 1;
                idle_input();
                drain();
                calm = 1;
            end
            if (k > 75) calm = 0;
        end
        idle_input();

        fork
            drain();
            begin
                repeat (400000) @(posedge aclk);
                $display("timeout waiting for results");
                errors++;
            end
        join_any
        disable fork;
        repeat (300) @(posedge aclk);

        $display("sent %0d words in %0d events, %0d clusters checked",
                 n_words, n_events, n_clusters);
        if (errors == 0 && clusters_due.size() == 0) begin
            $display("[strip_cluster_finder] OK");
        end else begin
            $display("[strip_cluster_finder] ERROR");
        end
        $finish;
    end

    // Hard limit on the run
    initial begin
        #20ms;
        $display("[strip_cluster_finder] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
